// ===== hdl/fdc_pkg.sv =====
// fdc_pkg: shared sizes, codes and helpers for the flip-dot chain refresh block
// depends on nothing; used by every module of the block except fdc_ram

package fdc_pkg;

  // panel geometry
  localparam int MODULE_WIDTH  = 5;
  localparam int MODULE_HEIGHT = 7;
  localparam int MAX_X_MODULES = 8;
  localparam int MAX_Y_MODULES = 4;

  localparam int PANEL_STRIDE = MAX_X_MODULES * MODULE_WIDTH;
  localparam int PANEL_ROWS   = MAX_Y_MODULES * MODULE_HEIGHT;
  localparam int STORE_DEPTH  = PANEL_STRIDE * PANEL_ROWS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  // request and register field widths
  localparam int PX_W   = 6;
  localparam int PY_W   = 5;
  localparam int XM_W   = 4;
  localparam int YM_W   = 3;
  localparam int CFG_W  = 4;
  localparam int CIDX_W = 2;
  localparam int BYTE_W = 8;

  // internal counter widths
  localparam int COL_W  = (MODULE_WIDTH > 1) ? $clog2(MODULE_WIDTH) : 1;
  localparam int ROW_W  = (MODULE_HEIGHT > 1) ? $clog2(MODULE_HEIGHT) : 1;
  localparam int MC_W   = (MAX_X_MODULES > 1) ? $clog2(MAX_X_MODULES) : 1;
  localparam int MR_W   = (MAX_Y_MODULES > 1) ? $clog2(MAX_Y_MODULES) : 1;
  localparam int XCNT_W = $clog2(MAX_X_MODULES + 1);
  localparam int YCNT_W = $clog2(MAX_Y_MODULES + 1);

  // width for the pixel bound compares
  localparam int XLIM_W = $clog2(PANEL_STRIDE + 1);
  localparam int YLIM_W = $clog2(PANEL_ROWS + 1);
  localparam int CMPX_W = (XLIM_W > PX_W) ? XLIM_W : PX_W;
  localparam int CMPY_W = (YLIM_W > PY_W) ? YLIM_W : PY_W;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_X_MODULES = 2'd0;
  localparam logic [CIDX_W-1:0] REG_Y_MODULES = 2'd1;
  localparam logic [CIDX_W-1:0] REG_INVERT    = 2'd2;

  // request commands
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic pix_write;
    logic load;
    logic issue;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic issue_last;
  } ctl_status_t;

  // module count register to a usable count
  function automatic logic [XCNT_W-1:0] clamp_x(input logic [XM_W-1:0] v);
    logic [XCNT_W-1:0] r;
    if (v == '0) r = XCNT_W'(1);
    else if (int'(v) > MAX_X_MODULES) r = XCNT_W'(MAX_X_MODULES);
    else r = XCNT_W'(v);
    return r;
  endfunction

  function automatic logic [YCNT_W-1:0] clamp_y(input logic [YM_W-1:0] v);
    logic [YCNT_W-1:0] r;
    if (v == '0) r = YCNT_W'(1);
    else if (int'(v) > MAX_Y_MODULES) r = YCNT_W'(MAX_Y_MODULES);
    else r = YCNT_W'(v);
    return r;
  endfunction

endpackage

// ===== hdl/fdc_ram.sv =====
// fdc_ram: generic single write port, single read port RAM with registered read
// depends on nothing

module fdc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fdc_ctrl.sv =====
// fdc_ctrl: state machine sequencing clear pass, pixel writes and refresh steps
// depends on fdc_pkg

module fdc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 command,
  input  fdc_pkg::ctl_status_t status,
  output fdc_pkg::ctl_cmd_t    cmd,
  output logic                 busy
);

  fdc_pkg::ctl_state_t state, state_next;
  logic accept;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy   = (state != fdc_pkg::ST_IDLE);
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd.clear_en  = 1'b0;
    cmd.pix_write = 1'b0;
    cmd.load      = 1'b0;
    cmd.issue     = 1'b0;
    case (state)
      fdc_pkg::ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) state_next = fdc_pkg::ST_IDLE;
      end
      fdc_pkg::ST_IDLE: begin
        if (accept) begin
          if (command == fdc_pkg::CMD_REFRESH) begin
            cmd.load   = 1'b1;
            state_next = fdc_pkg::ST_SCAN;
          end else begin
            cmd.pix_write = 1'b1;
          end
        end
      end
      fdc_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.issue_last) state_next = fdc_pkg::ST_IDLE;
      end
      default: begin
        state_next = fdc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/fdc_datapath.sv =====
// fdc_datapath: configuration, frame store, scan position and drive byte pipeline
// depends on fdc_pkg and fdc_ram

module fdc_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  fdc_pkg::ctl_cmd_t          cmd,
  output fdc_pkg::ctl_status_t       status,
  input  logic                       cfg_we,
  input  logic [fdc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [fdc_pkg::CFG_W-1:0]  cfg_data,
  input  logic [fdc_pkg::PX_W-1:0]   pixel_x,
  input  logic [fdc_pkg::PY_W-1:0]   pixel_y,
  input  logic                       pixel_on,
  output logic                       result_valid,
  output logic [fdc_pkg::BYTE_W-1:0] shift_byte,
  output logic                       latch_now,
  output logic                       frame_done
);

  // configuration registers
  logic [fdc_pkg::XM_W-1:0] x_modules;
  logic [fdc_pkg::YM_W-1:0] y_modules;
  logic                     invert;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_modules <= fdc_pkg::XM_W'(1);
      y_modules <= fdc_pkg::YM_W'(1);
      invert    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fdc_pkg::REG_X_MODULES: x_modules <= cfg_data[fdc_pkg::XM_W-1:0];
        fdc_pkg::REG_Y_MODULES: y_modules <= cfg_data[fdc_pkg::YM_W-1:0];
        fdc_pkg::REG_INVERT:    invert    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [fdc_pkg::XCNT_W-1:0] xm;
  logic [fdc_pkg::YCNT_W-1:0] ym;
  assign xm = fdc_pkg::clamp_x(x_modules);
  assign ym = fdc_pkg::clamp_y(y_modules);

  // clearing pass address
  logic [fdc_pkg::ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en && !status.clear_last) begin
      clr_addr <= clr_addr + fdc_pkg::ADDR_W'(1);
    end
  end

  assign status.clear_last = (clr_addr == fdc_pkg::ADDR_W'(fdc_pkg::STORE_DEPTH - 1));

  // pixel write bounds and address
  logic [fdc_pkg::CMPX_W-1:0] x_lim;
  logic [fdc_pkg::CMPY_W-1:0] y_lim;
  logic                       pix_in;
  logic [fdc_pkg::ADDR_W-1:0] pix_addr;

  assign x_lim  = fdc_pkg::CMPX_W'(xm) * fdc_pkg::CMPX_W'(fdc_pkg::MODULE_WIDTH);
  assign y_lim  = fdc_pkg::CMPY_W'(ym) * fdc_pkg::CMPY_W'(fdc_pkg::MODULE_HEIGHT);
  assign pix_in = (fdc_pkg::CMPX_W'(pixel_x) < x_lim) && (fdc_pkg::CMPY_W'(pixel_y) < y_lim);
  assign pix_addr = fdc_pkg::ADDR_W'(pixel_y) * fdc_pkg::ADDR_W'(fdc_pkg::PANEL_STRIDE)
                  + fdc_pkg::ADDR_W'(pixel_x);

  // scan position and step state
  logic [fdc_pkg::COL_W-1:0] scan_column;
  logic [fdc_pkg::ROW_W-1:0] scan_row;
  logic                      disable_phase;
  logic [fdc_pkg::COL_W-1:0] step_col;
  logic [fdc_pkg::ROW_W-1:0] step_row;
  logic                      step_dis;
  logic [fdc_pkg::MR_W-1:0]  mr;
  logic [fdc_pkg::MC_W-1:0]  mi;
  logic [fdc_pkg::MC_W-1:0]  mi_last;

  assign mi_last           = fdc_pkg::MC_W'(xm - fdc_pkg::XCNT_W'(1));
  assign status.issue_last = (mr == '0) && (mi == mi_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column   <= '0;
      scan_row      <= '0;
      disable_phase <= 1'b0;
    end else if (cmd.load) begin
      if (disable_phase) begin
        disable_phase <= 1'b0;
      end else if (scan_row == fdc_pkg::ROW_W'(fdc_pkg::MODULE_HEIGHT - 1)) begin
        scan_row <= '0;
        if (scan_column == fdc_pkg::COL_W'(fdc_pkg::MODULE_WIDTH - 1)) begin
          scan_column   <= '0;
          disable_phase <= 1'b1;
        end else begin
          scan_column <= scan_column + fdc_pkg::COL_W'(1);
        end
      end else begin
        scan_row <= scan_row + fdc_pkg::ROW_W'(1);
      end
    end
  end

  // module walk: bottom module row first, serpentine across
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step_col <= scan_column;
      step_row <= scan_row;
      step_dis <= disable_phase;
      mr       <= fdc_pkg::MR_W'(ym - fdc_pkg::YCNT_W'(1));
      mi       <= '0;
    end else if (cmd.issue) begin
      if (mi == mi_last) begin
        mi <= '0;
        mr <= mr - fdc_pkg::MR_W'(1);
      end else begin
        mi <= mi + fdc_pkg::MC_W'(1);
      end
    end
  end

  // dot address of the current module
  logic [fdc_pkg::MC_W-1:0]   mc;
  logic [fdc_pkg::ADDR_W-1:0] gx;
  logic [fdc_pkg::ADDR_W-1:0] gy;
  logic [fdc_pkg::ADDR_W-1:0] rd_addr;

  assign mc = mr[0] ? (mi_last - mi) : mi;
  assign gx = fdc_pkg::ADDR_W'(mc) * fdc_pkg::ADDR_W'(fdc_pkg::MODULE_WIDTH)
            + fdc_pkg::ADDR_W'(step_col);
  assign gy = fdc_pkg::ADDR_W'(mr) * fdc_pkg::ADDR_W'(fdc_pkg::MODULE_HEIGHT)
            + fdc_pkg::ADDR_W'(step_row);
  assign rd_addr = gy * fdc_pkg::ADDR_W'(fdc_pkg::PANEL_STRIDE) + gx;

  // frame store
  logic                       st_we;
  logic [fdc_pkg::ADDR_W-1:0] st_waddr;
  logic                       st_wdata;
  logic                       dot;

  assign st_we    = cmd.clear_en || (cmd.pix_write && pix_in);
  assign st_waddr = cmd.clear_en ? clr_addr : pix_addr;
  assign st_wdata = cmd.clear_en ? 1'b0 : pixel_on;

  fdc_ram #(
    .WIDTH (1),
    .DEPTH (fdc_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (dot)
  );

  // stage alongside the read data
  logic                      s1_valid;
  logic                      s1_last;
  logic                      s1_dis;
  logic [fdc_pkg::COL_W-1:0] s1_col;
  logic [fdc_pkg::ROW_W-1:0] s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_last <= status.issue_last;
    s1_dis  <= step_dis;
    s1_col  <= step_col;
    s1_row  <= step_row;
  end

  // drive byte assembly
  logic                       setrow;
  logic [fdc_pkg::BYTE_W-1:0] byte_next;

  assign setrow    = dot ^ invert;
  assign byte_next = s1_dis ? '0 : {3'(s1_col), ~setrow, 3'(s1_row), setrow};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    shift_byte <= byte_next;
    latch_now  <= s1_last;
    frame_done <= s1_dis;
  end

endmodule

// ===== hdl/flipdot_chain_refresh_top.sv =====
// flipdot_chain_refresh_top: frame store and refresh sequencer for a chained flip-dot panel
// depends on fdc_pkg, fdc_ctrl, fdc_datapath (which holds fdc_ram)
//
//  channel   ports                                     handshake
//  request   command, pixel_x, pixel_y, pixel_on       start high, busy low
//  result    shift_byte, latch_now, frame_done         result_valid, one cycle each
//  config    cfg_index, cfg_data                       cfg_we, no wait
//
// after reset busy stays high while the frame store is cleared one dot a cycle
// a pixel write goes into the frame store as the request is taken and busy stays low
// a refresh step keeps busy high while it issues one frame store read per module,
// and the next request is taken once the read for the last module has been issued
// results follow one per cycle, through the read stage and the output register
// results cannot be held off; each byte is valid for exactly one cycle

module flipdot_chain_refresh_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       command,
  input  logic [fdc_pkg::PX_W-1:0]   pixel_x,
  input  logic [fdc_pkg::PY_W-1:0]   pixel_y,
  input  logic                       pixel_on,
  input  logic                       cfg_we,
  input  logic [fdc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [fdc_pkg::CFG_W-1:0]  cfg_data,
  output logic                       result_valid,
  output logic [fdc_pkg::BYTE_W-1:0] shift_byte,
  output logic                       latch_now,
  output logic                       frame_done
);

  fdc_pkg::ctl_cmd_t    cmd;
  fdc_pkg::ctl_status_t status;

  // sequencing
  fdc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // storage and byte generation
  fdc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_on     (pixel_on),
    .result_valid (result_valid),
    .shift_byte   (shift_byte),
    .latch_now    (latch_now),
    .frame_done   (frame_done)
  );

endmodule
